// ----- hdl/sorted_list_insert_merge_assert.svh -----
// ----------------------------------------------------------------------------
// Sorted list insert/merge assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_MERGE_ASSERT_SVH
`define SORTED_LIST_INSERT_MERGE_ASSERT_SVH

// Combinational invariant checked at every clock edge
`define SLIM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication: ante at this edge gives cons at the next edge
`define SLIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/slim_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted list insert/merge package
// Sizes, codes and shared types of the sorted list block.
// ----------------------------------------------------------------------------
package slim_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int VAL_W      = 31;
  localparam int ST_W       = 2;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_MERGE   = 1'b1;
  localparam logic LIST_FIRST = 1'b0;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  // command broadcast to every cell of one chain
  typedef struct packed {
    cell_op_t         op;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

  // what the control logic sees of one chain
  typedef struct packed {
    logic [VAL_W-1:0] head_value;
    logic             head_valid;
    logic             second_valid;
    logic             full;
  } chain_stat_t;

endpackage

// ----- hdl/sorted_list_insert_merge.sv -----
// ----------------------------------------------------------------------------
// Sorted list insert/merge
// Two bounded ascending lists kept in chains of compare-and-shift cells.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. In an insert
// transaction every cell of the selected chain compares against the new
// value in parallel and the chain shifts in place, so inserts go back to
// back at one per cycle while busy is low, each answered in the next cycle
// by a single out_valid strobe (status ok or full). A merge transaction with
// N stored values raises busy and emits its N values at one per cycle,
// smallest first, picked by comparing the two chain heads and popping the
// winner; the final value carries out_last and both lists end up empty. The
// pop of each chain is one cell-to-cell shift, which sets the one value per
// cycle drain. A merge of two empty lists gives one strobe with status empty
// and does not raise busy. Results cannot be held off: each is on the out_
// ports for exactly one cycle with out_valid high. There is no clearing
// pass after reset; only the state, out_valid and cell valid flags are reset.
// ----------------------------------------------------------------------------
module sorted_list_insert_merge
  import slim_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_opcode,
  input  logic             in_list_select,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_value,
  output logic [ST_W-1:0]  out_status,
  output logic             out_last
);

`include "sorted_list_insert_merge_assert.svh"

  state_t state_r, state_nxt;

  cell_cmd_t   cmd_a, cmd_b;
  chain_stat_t stat_a, stat_b;

  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic accept;
  logic any_stored;
  logic pop_a;
  logic last_pop;
  logic sel_full;

  // --- chains ---------------------------------------------------------------
  slim_chain u_chain_a (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_a),
    .stat  (stat_a)
  );

  slim_chain u_chain_b (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_b),
    .stat  (stat_b)
  );

  // --- shared decode --------------------------------------------------------
  assign busy       = (state_r == S_DRAIN);
  assign accept     = start && !busy;
  assign any_stored = stat_a.head_valid || stat_b.head_valid;
  assign sel_full   = (in_list_select == LIST_FIRST) ? stat_a.full : stat_b.full;

  // head compare: ties go to the first list
  assign pop_a = stat_a.head_valid &&
                 (!stat_b.head_valid || (stat_a.head_value <= stat_b.head_value));

  // this pop empties both chains
  assign last_pop = (pop_a ? !stat_a.second_valid : !stat_a.head_valid) &&
                    (pop_a ? !stat_b.head_valid   : !stat_b.second_valid);

  // --- next state -----------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_opcode == OP_MERGE) && any_stored) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (last_pop) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --- outputs and chain commands -------------------------------------------
  always_comb begin
    cmd_a.op       = CELL_HOLD;
    cmd_a.value    = in_value;
    cmd_b.op       = CELL_HOLD;
    cmd_b.value    = in_value;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = ST_OK;
    out_last_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_INSERT) begin
            out_valid_nxt  = 1'b1;
            out_last_nxt   = 1'b1;
            out_status_nxt = sel_full ? ST_FULL : ST_OK;
            if (!sel_full) begin
              if (in_list_select == LIST_FIRST) begin
                cmd_a.op = CELL_INSERT;
              end else begin
                cmd_b.op = CELL_INSERT;
              end
            end
          end else if (!any_stored) begin
            out_valid_nxt  = 1'b1;
            out_last_nxt   = 1'b1;
            out_status_nxt = ST_EMPTY;
          end
        end
      end
      S_DRAIN: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = last_pop;
        if (pop_a) begin
          cmd_a.op      = CELL_POP;
          out_value_nxt = stat_a.head_value;
        end else begin
          cmd_b.op      = CELL_POP;
          out_value_nxt = stat_b.head_value;
        end
      end
      default: ;
    endcase
  end

  // --- registers ------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // --- assertions -----------------------------------------------------------
  `SLIM_ASSERT(a_drain_nonempty, !busy || stat_a.head_valid || stat_b.head_valid,
               "drain running with both chains empty")
  `SLIM_ASSERT_NEXT(a_insert_ack, accept && (in_opcode == OP_INSERT),
                    out_valid && out_last && (out_value == '0),
                    "insert transaction not acknowledged next cycle")
  `SLIM_ASSERT(a_more_follows, !(out_valid && !out_last) || busy,
               "non-final merge result with no drain in progress")
  `SLIM_ASSERT_NEXT(a_drain_order, busy && !last_pop,
                    out_value_r <= (stat_a.head_valid && (!stat_b.head_valid ||
                      stat_a.head_value <= stat_b.head_value)
                      ? stat_a.head_value : stat_b.head_value),
                    "merge results out of ascending order")

endmodule

// ----- hdl/slim_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted list cell
// One slot of a sorted chain: takes the new value, shifts from its left
// neighbor on insert, or shifts from its right neighbor on pop.
// ----------------------------------------------------------------------------
module slim_cell
  import slim_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] left_value,
  input  logic             left_valid,
  input  logic             left_place,
  input  logic [VAL_W-1:0] right_value,
  input  logic             right_valid,
  output logic [VAL_W-1:0] value,
  output logic             valid,
  output logic             place
);

  logic [VAL_W-1:0] value_r, value_nxt;
  logic             valid_r, valid_nxt;

  // new value belongs here or further left (equal values stay ahead)
  assign place = !valid_r || (value_r > cmd.value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (place) begin
          value_nxt = left_place ? left_value : cmd.value;
          valid_nxt = valid_r | left_valid;
        end
      end
      CELL_POP: begin
        value_nxt = right_value;
        valid_nxt = right_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// ----- hdl/slim_chain.sv -----
// ----------------------------------------------------------------------------
// Sorted list chain
// A row of cells holding one ascending list, head at cell 0.
// ----------------------------------------------------------------------------
module slim_chain
  import slim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  output chain_stat_t stat
);

  logic [VAL_W-1:0] cell_value [LIST_DEPTH];
  logic             cell_valid [LIST_DEPTH];
  logic             cell_place [LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] lv, rv;
    logic             lvalid, lplace, rvalid;

    if (i == 0) begin : g_head
      assign lv     = '0;
      assign lvalid = 1'b1;
      assign lplace = 1'b0;
    end else begin : g_mid
      assign lv     = cell_value[i-1];
      assign lvalid = cell_valid[i-1];
      assign lplace = cell_place[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign rv     = '0;
      assign rvalid = 1'b0;
    end else begin : g_body
      assign rv     = cell_value[i+1];
      assign rvalid = cell_valid[i+1];
    end

    slim_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_value  (lv),
      .left_valid  (lvalid),
      .left_place  (lplace),
      .right_value (rv),
      .right_valid (rvalid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .place       (cell_place[i])
    );
  end

  assign stat.head_value   = cell_value[0];
  assign stat.head_valid   = cell_valid[0];
  assign stat.second_valid = cell_valid[1];
  assign stat.full         = cell_valid[LIST_DEPTH-1];

endmodule
